// File: hw/rtl/spa_pkg.sv
// Shared types and codes of the slot pool allocator.
package spa_pkg;

    // Width of the slot number field carried by a result transaction.
    localparam int unsigned SLOT_NUM_W = 4;

    // Command codes.
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Payload of a command transaction.
    typedef struct packed {
        logic                  command;
        logic [SLOT_NUM_W-1:0] release_slot;
    } t_cmd;

    // Payload of a result transaction.
    typedef struct packed {
        logic                  granted;
        logic [SLOT_NUM_W-1:0] slot_number;
        logic                  reused_oldest;
    } t_res;

endpackage

// File: hw/rtl/spa_cmd_if.sv
// Valid/ready channel that carries command transactions.
interface spa_cmd_if import spa_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/spa_res_if.sv
// Valid/ready channel that carries result transactions.
interface spa_res_if import spa_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/slot_pool_allocator_oldest_reuse.sv
// Slot pool allocator: a small sequencer walks the active marks and a circular order queue held
// in RAM, one entry per step. An allocate checks the marks from slot 0 upwards until it finds
// the lowest free slot, or, when every slot is active, reuses the oldest one (the queue head
// simply advances). A release of an active slot reads and compares the queue entries up to and
// including its position, moves each later entry up one place and then finishes; a release of
// a free or out-of-range slot goes straight to the finish. The single RAM read port has
// registered read data, so each queue read is issued in its own state before its data is used.
// The result waits in an output register, so the block accepts the next command while it is
// not yet taken; a finished result whose register is still occupied waits for as long as the
// receiver stalls. No clearing pass is needed after reset.
module slot_pool_allocator_oldest_reuse import spa_pkg::*; #(
    parameter int unsigned POOL_SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spa_cmd_if.sink    i_cmd,
    spa_res_if.source  o_res
);

    localparam int unsigned SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int unsigned CW = $clog2(POOL_SLOTS + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FREE     = 4'd1;
    localparam logic [3:0] S_OLD_RD   = 4'd2;
    localparam logic [3:0] S_OLD_DONE = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CMP = 4'd5;
    localparam logic [3:0] S_SH_RD    = 4'd6;
    localparam logic [3:0] S_SH_WR    = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0]            r_state, n_state;
    logic [POOL_SLOTS-1:0] r_marks, n_marks;
    logic [SW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_k, n_k;
    logic [SW-1:0]         r_rel, n_rel;
    t_res                  r_pend, n_pend;
    logic                  r_out_valid, n_out_valid;
    t_res                  r_out, n_out;

    logic                  ram_wr_en;
    logic [SW-1:0]         ram_wr_addr;
    logic [SW-1:0]         ram_wr_data;
    logic [SW-1:0]         ram_rd_addr;
    logic [SW-1:0]         ram_rd_data;

    logic [SW+3:0]         rel_ext;
    logic [SW-1:0]         k_slot;
    logic [CW:0]           k_next;

    // Adds two positions below the pool size and wraps the sum around the circular queue.
    function automatic logic [SW-1:0] wrap_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0] s;
        s = (SW+1)'(a) + (SW+1)'(b);
        if (s >= (SW+1)'(POOL_SLOTS)) begin
            s = s - (SW+1)'(POOL_SLOTS);
        end
        return s[SW-1:0];
    endfunction

    // Low bits of a slot number as carried by a result transaction.
    function automatic logic [SLOT_NUM_W-1:0] slot_field(input logic [SW-1:0] slot);
        logic [SW+SLOT_NUM_W-1:0] ext;
        ext = (SW+SLOT_NUM_W)'(slot);
        return ext[SLOT_NUM_W-1:0];
    endfunction

    // Order queue storage.
    spa_ram #(
        .WIDTH (SW),
        .DEPTH (POOL_SLOTS)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign rel_ext = (SW+4)'(i_cmd.data.release_slot);
    assign k_slot  = r_k[SW-1:0];
    assign k_next  = (CW+1)'(r_k) + (CW+1)'(1);

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Sequencer and queue bookkeeping.
    always_comb begin
        n_state     = r_state;
        n_marks     = r_marks;
        n_head      = r_head;
        n_count     = r_count;
        n_k         = r_k;
        n_rel       = r_rel;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_wr_en   = 1'b0;
        ram_wr_addr = wrap_add(r_head, SW'(r_count));
        ram_wr_data = k_slot;
        ram_rd_addr = r_head;

        // The output register empties when its transaction completes.
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_k = '0;
                    if (i_cmd.data.command == CMD_RELEASE) begin
                        n_pend.granted       = 1'b0;
                        n_pend.slot_number   = i_cmd.data.release_slot;
                        n_pend.reused_oldest = 1'b0;
                        n_rel                = rel_ext[SW-1:0];
                        if (rel_ext >= (SW+4)'(POOL_SLOTS)) begin
                            n_state = S_DONE;
                        end else if (!r_marks[rel_ext[SW-1:0]]) begin
                            n_state = S_DONE;
                        end else begin
                            n_marks[rel_ext[SW-1:0]] = 1'b0;
                            n_state                  = S_SCAN_RD;
                        end
                    end else if (r_count == CW'(POOL_SLOTS)) begin
                        n_state = S_OLD_RD;
                    end else begin
                        n_state = S_FREE;
                    end
                end
            end
            S_FREE: begin
                // Look for the lowest free slot, one mark per cycle.
                if (!r_marks[k_slot]) begin
                    n_marks[k_slot]      = 1'b1;
                    ram_wr_en            = 1'b1;
                    n_count              = r_count + CW'(1);
                    n_pend.granted       = 1'b1;
                    n_pend.slot_number   = slot_field(k_slot);
                    n_pend.reused_oldest = 1'b0;
                    n_state              = S_DONE;
                end else begin
                    n_k = k_next[CW-1:0];
                end
            end
            S_OLD_RD: begin
                ram_rd_addr = r_head;
                n_state     = S_OLD_DONE;
            end
            S_OLD_DONE: begin
                // With the queue full, moving the head to the tail is a pointer step.
                n_head               = wrap_add(r_head, SW'(1));
                n_pend.granted       = 1'b1;
                n_pend.slot_number   = slot_field(ram_rd_data);
                n_pend.reused_oldest = 1'b1;
                n_state              = S_DONE;
            end
            S_SCAN_RD: begin
                ram_rd_addr = wrap_add(r_head, k_slot);
                n_state     = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (ram_rd_data == r_rel) begin
                    n_state = S_SH_RD;
                end else if (k_next >= (CW+1)'(r_count)) begin
                    n_state = S_DONE;
                end else begin
                    n_k     = k_next[CW-1:0];
                    n_state = S_SCAN_RD;
                end
            end
            S_SH_RD: begin
                // Close the gap: each later entry moves up one place.
                if (k_next >= (CW+1)'(r_count)) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    ram_rd_addr = wrap_add(r_head, k_next[SW-1:0]);
                    n_state     = S_SH_WR;
                end
            end
            S_SH_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = wrap_add(r_head, k_slot);
                ram_wr_data = ram_rd_data;
                n_k         = k_next[CW-1:0];
                n_state     = S_SH_RD;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_marks     <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_marks     <= n_marks;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_rel  <= n_rel;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

endmodule

// File: hw/rtl/spa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module spa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
